// File: rtl/core/oqkr_pkg.sv
// ----------------------------------------------------------------------------
// oqkr_pkg
// Shared types and codes for the ordered queue with keyed removal: the
// operation and status codes, the beat structs of both channels and the
// sequencer states.
// ----------------------------------------------------------------------------
package oqkr_pkg;

    // Operation codes carried by an input beat
    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_FIND   = 2'd2,
        OP_REMOVE = 2'd3
    } t_op;

    // Status codes carried by a result beat
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } t_status;

    // Input beat
    typedef struct packed {
        t_op         op;
        logic [15:0] handle_value;
    } t_in_item;

    // Result beat
    typedef struct packed {
        t_status     status;
        logic [15:0] out_value;
        logic [3:0]  match_position;
        logic [4:0]  occupancy;
    } t_out_item;

    // Per-cell controls for one cycle
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Operation sequencer
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SEARCH = 2'd1,
        ST_APPLY  = 2'd2
    } t_state;

endpackage

// File: rtl/core/oqkr_cell.sv
// ----------------------------------------------------------------------------
// oqkr_cell
// One queue slot: holds a value, loads a new value on append, takes its
// neighbour's value when the queue closes up, and compares against the key.
// ----------------------------------------------------------------------------
module oqkr_cell
    import oqkr_pkg::*;
#(
    parameter int VALUE_BITS = 16
) (
    input  logic                  i_clk,
    input  t_cell_ctl             i_ctl,
    input  logic [VALUE_BITS-1:0] i_key,
    input  logic [VALUE_BITS-1:0] i_next,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_hit
);

    logic [VALUE_BITS-1:0] r_value;

    // Slot storage: append has priority, else close up from the tail side
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_value <= i_key;
        end else if (i_ctl.shift) begin
            r_value <= i_next;
        end
    end

    assign o_value = r_value;
    assign o_hit   = (r_value == i_key);

endmodule

// File: rtl/core/oqkr_first_match.sv
// ----------------------------------------------------------------------------
// oqkr_first_match
// Finds the hit nearest the head: a log-depth prefix OR marks every slot at
// or after the first hit, and the edge of that mask gives its position.
// ----------------------------------------------------------------------------
module oqkr_first_match
    import oqkr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]         i_hits,
    output logic                     o_found,
    output logic [$clog2(DEPTH)-1:0] o_pos,
    output logic [DEPTH-1:0]         o_from
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int LEVELS = $clog2(DEPTH);

    logic [DEPTH-1:0] prefix;
    logic [DEPTH-1:0] first;

    // Prefix OR toward the tail, doubling the span each level
    always_comb begin
        prefix = i_hits;
        for (int k = 0; k < LEVELS; k++) begin
            prefix = prefix | (prefix << (1 << k));
        end
    end

    // One-hot first hit, then encode its index
    always_comb begin
        first = prefix & ~(prefix << 1);
        o_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (first[i]) begin
                o_pos = o_pos | IDX_W'(i);
            end
        end
    end

    assign o_found = |i_hits;
    assign o_from  = prefix;

endmodule

// File: rtl/core/ordered_queue_with_keyed_removal.sv
// ----------------------------------------------------------------------------
// ordered_queue_with_keyed_removal
// Bounded ordered queue of handle values with append, head removal, search
// and removal of the first match, built as a row of shifting slots.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one operation
//   per beat: enqueue, dequeue head, find value or remove value. The result
//   channel (o_out_valid / i_out_ready / o_out_data) returns one beat per
//   operation, in order, with status, dequeued value, match position and
//   the occupancy after the operation.
//   Sequence: an accepted operation has its beat latched, then its slot
//   compares registered, then its first hit found and the row updated,
//   with the result register loaded in the same step once that register
//   is free. A new operation is taken only after the previous one has
//   updated the row; this is set by the three-step sequencer shared by
//   the whole row of slots.
//   Stall: a finished result waits in the output register while the next
//   operation is accepted and searched; the update step holds until the
//   register is free or being taken.
//   Reset: i_rst_n (synchronous, active low) empties the queue and drops any
//   pending result. Slot contents are not cleared; only held slots are read.
// ----------------------------------------------------------------------------
module ordered_queue_with_keyed_removal
    import oqkr_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int KEEP_W = (VALUE_BITS < 16) ? VALUE_BITS : 16;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    t_op                   r_op;
    logic [VALUE_BITS-1:0] r_key;
    logic [DEPTH-1:0]      r_match;
    logic                  r_out_valid;
    t_out_item             r_out, n_out;

    logic                  in_go;
    logic                  apply_go;
    logic                  is_full;
    logic                  is_empty;
    logic                  found;
    logic [IDX_W-1:0]      pos;
    logic [DEPTH-1:0]      from;
    logic [DEPTH-1:0]      hits;
    logic [DEPTH-1:0]      live;
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    t_cell_ctl             cell_ctl   [DEPTH];

    assign in_go    = i_in_valid && o_in_ready;
    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);

    // Row of slots; each hands its value to the slot nearer the head
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] next_value;

        if (g == DEPTH - 1) begin : g_tail
            assign next_value = r_key;
        end else begin : g_body
            assign next_value = cell_value[g+1];
        end

        assign live[g] = (CNT_W'(g) < r_count);

        always_comb begin
            cell_ctl[g].load  = apply_go && (r_op == OP_ENQ) && !is_full &&
                                (r_count == CNT_W'(g));
            cell_ctl[g].shift = apply_go &&
                                (((r_op == OP_DEQ) && !is_empty) ||
                                 ((r_op == OP_REMOVE) && found && from[g]));
        end

        oqkr_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl[g]),
            .i_key   (r_key),
            .i_next  (next_value),
            .o_value (cell_value[g]),
            .o_hit   (hits[g])
        );
    end

    // First hit among the held slots
    oqkr_first_match #(
        .DEPTH (DEPTH)
    ) u_first_match (
        .i_hits  (r_match),
        .o_found (found),
        .o_pos   (pos),
        .o_from  (from)
    );

    // Sequencer: next state, handshake and result
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        apply_go   = 1'b0;
        o_in_ready = 1'b0;
        n_out      = '0;
        n_out.status = STS_OK;

        case (r_op)
            OP_ENQ: begin
                if (is_full) begin
                    n_out.status = STS_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_DEQ: begin
                if (is_empty) begin
                    n_out.status = STS_EMPTY;
                end else begin
                    n_out.out_value = 16'(cell_value[0]);
                    n_count         = r_count - CNT_W'(1);
                end
            end
            OP_FIND: begin
                if (found) begin
                    n_out.match_position = 4'(pos);
                end else begin
                    n_out.status = STS_NOT_FOUND;
                end
            end
            OP_REMOVE: begin
                if (found) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_out.status = STS_NOT_FOUND;
                end
            end
            default: begin
                n_out.status = STS_OK;
            end
        endcase
        n_out.occupancy = 5'(n_count);

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (!r_out_valid || i_out_ready) begin
                    apply_go = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (!apply_go) begin
            n_count = r_count;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (apply_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: accepted beat, masked compares, result
    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_op  <= i_in_data.op;
            r_key <= VALUE_BITS'(i_in_data.handle_value[KEEP_W-1:0]);
        end
        if (r_state == ST_SEARCH) begin
            r_match <= hits & live;
        end
        if (apply_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("occupancy beyond depth");

    a_accept_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_go |=> (r_state == ST_SEARCH))
        else $error("accepted beat not searched");

    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && (n_out.status != STS_OK)) |=> $stable(r_count))
        else $error("failed operation changed occupancy");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (apply_go && (r_op == OP_ENQ) && (n_out.status == STS_OK))
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append did not grow queue");

endmodule

// File: sim/ordered_queue_with_keyed_removal_tb.sv
// ----------------------------------------------------------------------------
// ordered_queue_with_keyed_removal_tb
// Self-checking bench for the ordered queue with keyed removal. A short table
// of directed operations covers the empty queue, a full queue, duplicates,
// misses and both ends of the row. Random operation mixes follow and swing
// the queue between empty and full. Every result beat is checked field by
// field against a behavioural copy of the queue or a pinned row's result.
// Both channels idle and stall at random, with quiet stretches between.
// ----------------------------------------------------------------------------
module ordered_queue_with_keyed_removal_tb;
    import oqkr_pkg::*;

    localparam int DEPTH         = 16;
    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_OPS    = 1600;
    localparam int SETTLE_CYCLES = 12;
    localparam int RUN_LIMIT     = 5_000_000;

    // Values that recur often enough for finds and removes to hit
    localparam logic [15:0] VALUE_POOL [8] = '{
        16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5,
        16'h0001, 16'h8000, 16'h1234, 16'hEDCB
    };

    // One directed operation; a pinned row carries its typed-in result
    typedef struct {
        t_op       kind;
        logic [15:0] value;
        bit        pinned;
        t_out_item pinned_result;
    } t_stim_row;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    logic [15:0] held_values [$];
    t_out_item   pending_results [$];
    t_stim_row   stim_table [$];
    int          mismatch_count = 0;
    int          beats_seen     = 0;
    int          cycle_count    = 0;
    logic        steady_run;

    ordered_queue_with_keyed_removal #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (16)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Cycle count; one stretch in five has no idling on either side
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end
    assign steady_run = (cycle_count % 5000) >= 4000;

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("MISMATCH: %s", msg);
    endtask

    // Behavioural queue: applies one operation and returns its result beat
    function automatic t_out_item apply_queue_op(input t_op kind, input logic [15:0] value);
        t_out_item res;
        int        hit;
        int        i;
        res = '0;
        res.status = STS_OK;
        hit = -1;
        for (i = 0; i < held_values.size(); i++) begin
            if (hit < 0 && held_values[i] == value) hit = i;
        end
        case (kind)
            OP_ENQ: begin
                if (held_values.size() >= DEPTH) res.status = STS_FULL;
                else held_values.push_back(value);
            end
            OP_DEQ: begin
                if (held_values.size() == 0) res.status = STS_EMPTY;
                else res.out_value = held_values.pop_front();
            end
            OP_FIND: begin
                if (hit < 0) res.status = STS_NOT_FOUND;
                else res.match_position = 4'(hit);
            end
            default: begin
                if (hit < 0) res.status = STS_NOT_FOUND;
                else held_values.delete(hit);
            end
        endcase
        res.occupancy = 5'(held_values.size());
        return res;
    endfunction

    function automatic void add_row(input t_op kind, input logic [15:0] value,
                                    input bit pinned, input t_status status,
                                    input logic [15:0] out_value,
                                    input logic [3:0] position,
                                    input logic [4:0] occupancy);
        t_stim_row row;
        row.kind                         = kind;
        row.value                        = value;
        row.pinned                       = pinned;
        row.pinned_result.status         = status;
        row.pinned_result.out_value      = out_value;
        row.pinned_result.match_position = position;
        row.pinned_result.occupancy      = occupancy;
        stim_table.push_back(row);
    endfunction

    function automatic void build_directed_table();
        int i;
        // Empty queue: every removing or searching operation misses
        add_row(OP_DEQ,    16'h0000, 1'b1, STS_EMPTY,     16'h0000, 4'd0, 5'd0);
        add_row(OP_FIND,   16'h0000, 1'b1, STS_NOT_FOUND, 16'h0000, 4'd0, 5'd0);
        add_row(OP_REMOVE, 16'hFFFF, 1'b1, STS_NOT_FOUND, 16'h0000, 4'd0, 5'd0);
        // Fill to the brim, value extremes first, a duplicate pair inside
        add_row(OP_ENQ,    16'h0000, 1'b1, STS_OK,        16'h0000, 4'd0, 5'd1);
        add_row(OP_ENQ,    16'hFFFF, 1'b1, STS_OK,        16'h0000, 4'd0, 5'd2);
        for (i = 2; i < DEPTH; i++) begin
            add_row(OP_ENQ, (i == 6 || i == 11) ? 16'h5A5A : 16'(i * 16'h1001),
                    1'b0, STS_OK, 16'h0000, 4'd0, 5'd0);
        end
        add_row(OP_ENQ,    16'h1234, 1'b1, STS_FULL,      16'h0000, 4'd0,  5'd16);
        // Search near the head and at the tail slot
        add_row(OP_FIND,   16'hFFFF, 1'b1, STS_OK,        16'h0000, 4'd1,  5'd16);
        add_row(OP_FIND,   16'hF00F, 1'b1, STS_OK,        16'h0000, 4'd15, 5'd16);
        // Duplicates: first match wins, the second moves up after removal
        add_row(OP_FIND,   16'h5A5A, 1'b0, STS_OK,        16'h0000, 4'd0,  5'd0);
        add_row(OP_REMOVE, 16'h5A5A, 1'b0, STS_OK,        16'h0000, 4'd0,  5'd0);
        add_row(OP_FIND,   16'h5A5A, 1'b0, STS_OK,        16'h0000, 4'd0,  5'd0);
        add_row(OP_REMOVE, 16'h0BAD, 1'b0, STS_OK,        16'h0000, 4'd0,  5'd0);
        add_row(OP_DEQ,    16'hFFFF, 1'b0, STS_OK,        16'h0000, 4'd0,  5'd0);
    endfunction

    // Present one beat, hold it until taken, then log its expected result
    task automatic send_op(input t_op kind, input logic [15:0] value,
                           input bit pinned, input t_out_item pinned_result);
        t_out_item predicted;
        while (!steady_run && $urandom_range(99) < 7) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{op: kind, handle_value: value};
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        predicted = apply_queue_op(kind, value);
        pending_results.push_back(pinned ? pinned_result : predicted);
    endtask

    // Stimulus: reset, directed table, then random mixes
    initial begin
        t_stim_row   row;
        int          k;
        int          mode;
        int          pick;
        t_op         kind;
        logic [15:0] value;
        build_directed_table();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < stim_table.size(); k++) begin
            row = stim_table[k];
            send_op(row.kind, row.value, row.pinned, row.pinned_result);
        end

        // Mixes rotate between filling, draining and balanced phases
        for (k = 0; k < RANDOM_OPS; k++) begin
            mode = (k / 120) % 3;
            pick = $urandom_range(99);
            case (mode)
                0: kind = (pick < 55) ? OP_ENQ : (pick < 65) ? OP_DEQ :
                          (pick < 85) ? OP_FIND : OP_REMOVE;
                1: kind = (pick < 15) ? OP_ENQ : (pick < 55) ? OP_DEQ :
                          (pick < 75) ? OP_FIND : OP_REMOVE;
                default: kind = (pick < 30) ? OP_ENQ : (pick < 55) ? OP_DEQ :
                                (pick < 80) ? OP_FIND : OP_REMOVE;
            endcase
            value = ($urandom_range(99) < 75) ? VALUE_POOL[$urandom_range(7)]
                                              : 16'($urandom);
            send_op(kind, value, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ordered_queue_with_keyed_removal_tb OK");
        end else begin
            $display("ordered_queue_with_keyed_removal_tb NOT OK");
        end
        $finish;
    end

    // Result side: random stalls, each beat checked against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n) begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("beat %0d: result with nothing expected",
                                            beats_seen));
                end else begin
                    want = pending_results.pop_front();
                    if (out_data.status !== want.status)
                        flag_mismatch($sformatf("beat %0d: status %0d, want %0d",
                                                beats_seen, out_data.status, want.status));
                    if (out_data.out_value !== want.out_value)
                        flag_mismatch($sformatf("beat %0d: out_value %h, want %h",
                                                beats_seen, out_data.out_value,
                                                want.out_value));
                    if (out_data.match_position !== want.match_position)
                        flag_mismatch($sformatf("beat %0d: match_position %0d, want %0d",
                                                beats_seen, out_data.match_position,
                                                want.match_position));
                    if (out_data.occupancy !== want.occupancy)
                        flag_mismatch($sformatf("beat %0d: occupancy %0d, want %0d",
                                                beats_seen, out_data.occupancy,
                                                want.occupancy));
                end
                beats_seen++;
            end
            out_ready <= steady_run || ($urandom_range(99) >= 7);
        end
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT);
        $display("ordered_queue_with_keyed_removal_tb NOT OK");
        $finish;
    end

endmodule
